[rtl/bpc_pkg.sv]
// Package for the pressure compensation block: calibration record, register
// indexes, formula constants and the arithmetic shift helper.
// No dependencies.
package bpc_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned CfgAddrW  = 5;
  localparam int unsigned TempW     = 28;
  localparam int unsigned RawTempW  = 16;
  localparam int unsigned RawPressW = 19;

  localparam logic [31:0] B6Offset = 32'd4000;
  localparam logic [31:0] B4Bias   = 32'd32768;
  localparam logic [31:0] B7Scale  = 32'd50000;
  localparam logic [31:0] PolyA    = 32'd3038;
  localparam logic [31:0] PolyB    = 32'hFFFF_E343; // -7357
  localparam logic [31:0] PolyC    = 32'd3791;
  localparam logic [31:0] RoundT   = 32'd8;
  localparam logic [31:0] RoundP   = 32'd2;

  typedef enum logic [2:0] {
    REG_AC1_AC2 = 3'd0,
    REG_AC3_AC4 = 3'd1,
    REG_AC5_AC6 = 3'd2,
    REG_B1_B2   = 3'd3,
    REG_MC_MD   = 3'd4,
    REG_OSS     = 3'd5
  } reg_idx_t;

  // calibration words, already widened to 32 bits, and the 2-bit oss setting
  typedef struct packed {
    logic [31:0] ac1;
    logic [31:0] ac2;
    logic [31:0] ac3;
    logic [31:0] ac4;
    logic [31:0] ac5;
    logic [31:0] ac6;
    logic [31:0] b1;
    logic [31:0] b2;
    logic [31:0] mc;
    logic [31:0] md;
    logic [1:0]  oss;
  } cal_t;

  function automatic logic [31:0] sra(input logic [31:0] v, input int unsigned s);
    logic signed [31:0] sv;
    sv = $signed(v);
    return 32'(sv >>> s);
  endfunction

endpackage

[rtl/bpc_if.sv]
// Channel interfaces for the pressure compensation block.
// Depends on bpc_pkg for field widths.
interface bpc_in_if;
  logic                               valid;
  logic                               ready;
  logic [bpc_pkg::RawTempW-1:0]       raw_temperature;
  logic [bpc_pkg::RawPressW-1:0]      raw_pressure;
  modport source(output valid, raw_temperature, raw_pressure, input ready);
  modport sink(input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface bpc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [bpc_pkg::TempW-1:0]   temperature_tenths;
  logic signed [bpc_pkg::DataW-1:0]   pressure_pa;
  logic                               divide_error;
  modport source(output valid, temperature_tenths, pressure_pa, divide_error, input ready);
  modport sink(input valid, temperature_tenths, pressure_pa, divide_error, output ready);
endinterface

[rtl/bpc_regs.sv]
// APB calibration register file for the pressure compensation block.
// Depends on bpc_pkg.
module bpc_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpc_pkg::CfgAddrW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output bpc_pkg::cal_t                 cal
);

  logic [31:0] ac1_ac2, ac3_ac4, ac5_ac6, b1_b2, mc_md;
  logic [1:0]  oss;
  bpc_pkg::reg_idx_t idx;

  assign idx = bpc_pkg::reg_idx_t'(paddr[bpc_pkg::CfgAddrW-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      ac1_ac2 <= '0;
      ac3_ac4 <= '0;
      ac5_ac6 <= '0;
      b1_b2   <= '0;
      mc_md   <= '0;
      oss     <= '0;
    end else if (psel && penable && pwrite) begin
      case (idx)
        bpc_pkg::REG_AC1_AC2: ac1_ac2 <= pwdata;
        bpc_pkg::REG_AC3_AC4: ac3_ac4 <= pwdata;
        bpc_pkg::REG_AC5_AC6: ac5_ac6 <= pwdata;
        bpc_pkg::REG_B1_B2:   b1_b2   <= pwdata;
        bpc_pkg::REG_MC_MD:   mc_md   <= pwdata;
        bpc_pkg::REG_OSS:     oss     <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      bpc_pkg::REG_AC1_AC2: prdata = ac1_ac2;
      bpc_pkg::REG_AC3_AC4: prdata = ac3_ac4;
      bpc_pkg::REG_AC5_AC6: prdata = ac5_ac6;
      bpc_pkg::REG_B1_B2:   prdata = b1_b2;
      bpc_pkg::REG_MC_MD:   prdata = mc_md;
      bpc_pkg::REG_OSS:     prdata = {30'd0, oss};
      default:              prdata = '0;
    endcase
  end

  always_comb begin
    cal.ac1 = {{16{ac1_ac2[31]}}, ac1_ac2[31:16]};
    cal.ac2 = {{16{ac1_ac2[15]}}, ac1_ac2[15:0]};
    cal.ac3 = {{16{ac3_ac4[31]}}, ac3_ac4[31:16]};
    cal.ac4 = {16'd0, ac3_ac4[15:0]};
    cal.ac5 = {16'd0, ac5_ac6[31:16]};
    cal.ac6 = {16'd0, ac5_ac6[15:0]};
    cal.b1  = {{16{b1_b2[31]}}, b1_b2[31:16]};
    cal.b2  = {{16{b1_b2[15]}}, b1_b2[15:0]};
    cal.mc  = {{16{mc_md[31]}}, mc_md[31:16]};
    cal.md  = {{16{mc_md[15]}}, mc_md[15:0]};
    cal.oss = oss;
  end

endmodule

[rtl/bpc_div.sv]
// Pipelined restoring unsigned divider, one quotient bit per stage, with a
// sideband word that travels alongside. No dependencies.
module bpc_div #(
  parameter int unsigned W      = 32,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [W-1:0]      dividend,
  input  logic [W-1:0]      divisor,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [W-1:0]      quotient,
  output logic [SIDE_W-1:0] side_out
);

  logic              vld [W+1];
  logic [W-1:0]      rm  [W+1];
  logic [W-1:0]      nq  [W+1];
  logic [W-1:0]      dv  [W+1];
  logic [SIDE_W-1:0] sd  [W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rm[0] <= '0;
      nq[0] <= dividend;
      dv[0] <= divisor;
      sd[0] <= side_in;
    end
  end

  for (genvar k = 0; k < W; k++) begin : g_step
    logic [W:0] trial;
    logic [W:0] diff;
    logic       ge;

    assign trial = {rm[k], nq[k][W-1]};
    assign diff  = trial - {1'b0, dv[k]};
    assign ge    = !diff[W];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rm[k+1] <= ge ? diff[W-1:0] : trial[W-1:0];
        nq[k+1] <= {nq[k][W-2:0], ge};
        dv[k+1] <= dv[k];
        sd[k+1] <= sd[k];
      end
    end
  end

  assign out_valid = vld[W];
  assign quotient  = nq[W];
  assign side_out  = sd[W];

endmodule

[rtl/bpc_corr.sv]
// Final pressure correction polynomial, temperature rounding and result register.
// Depends on bpc_pkg.
module bpc_corr (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [31:0]                       quotient,
  input  logic [31:0]                       b5,
  input  logic                              err,
  input  logic                              big,
  output logic                              out_valid,
  output logic signed [bpc_pkg::TempW-1:0]  temperature_tenths,
  output logic signed [31:0]                pressure_pa,
  output logic                              divide_error
);

  logic [31:0] p, pa;
  logic [31:0] g_p, g_sq, g_x2, g_b5;
  logic        g_v, g_err;
  logic [31:0] h_p, h_x1, h_x2, h_b5;
  logic        h_v, h_err;
  logic [31:0] x2p, x1p, t_full, p_full;

  assign p   = big ? {quotient[30:0], 1'b0} : quotient;
  assign pa  = bpc_pkg::sra(p, 8);
  assign x2p = bpc_pkg::PolyB * p;
  assign x1p = g_sq * bpc_pkg::PolyA;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_v <= 1'b0;
      h_v <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      g_v <= in_valid;
      h_v <= g_v;
      out_valid <= h_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_p   <= p;
      g_sq  <= pa * pa;
      g_x2  <= bpc_pkg::sra(x2p, 16);
      g_b5  <= b5;
      g_err <= err;
      h_p   <= g_p;
      h_x1  <= bpc_pkg::sra(x1p, 16);
      h_x2  <= g_x2;
      h_b5  <= g_b5;
      h_err <= g_err;
    end
  end

  assign t_full = bpc_pkg::sra(h_b5 + bpc_pkg::RoundT, 4);
  assign p_full = h_p + bpc_pkg::sra(h_x1 + h_x2 + bpc_pkg::PolyC, 4);

  always_ff @(posedge clk) begin
    if (en) begin
      temperature_tenths <= h_err ? '0 : t_full[bpc_pkg::TempW-1:0];
      pressure_pa        <= h_err ? '0 : p_full;
      divide_error       <= h_err;
    end
  end

endmodule

[rtl/barometric_pressure_compensation_unit.sv]
// Top level of the pressure compensation block: register file, temperature
// and pressure dividers, coefficient stages and final correction.
// Depends on bpc_pkg, bpc_if, bpc_regs, bpc_div and bpc_corr.
//
//  channel   direction  payload                                          handshake
//  samples   in         raw_temperature, raw_pressure                    valid/ready
//  results   out        temperature_tenths, pressure_pa, divide_error    valid/ready
//  apb       in/out     paddr, pwdata, prdata                            psel/penable/pready
//
// One request per cycle while results is not stalled; the two dividers have 33 stages each.
// Reset (rst, synchronous) clears the valid bits and the calibration registers.
// A stalled result freezes the whole pipeline; samples.ready drops only then.
module barometric_pressure_compensation_unit (
  input  logic                          clk,
  input  logic                          rst,
  bpc_in_if.sink                        samples,
  bpc_out_if.source                     results,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpc_pkg::CfgAddrW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int unsigned TSideW = 32 + bpc_pkg::RawPressW + 2;
  localparam int unsigned PSideW = 32 + 2;

  bpc_pkg::cal_t cal;
  logic en;

  assign pready        = 1'b1;
  assign en            = !results.valid || results.ready;
  assign samples.ready = en;

  bpc_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cal
  );

  // temperature product
  logic        v1;
  logic [31:0] prod1;
  logic [bpc_pkg::RawPressW-1:0] up1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod1 <= ({16'd0, samples.raw_temperature} - cal.ac6) * cal.ac5;
      up1   <= samples.raw_pressure;
    end
  end

  // signed quotient through magnitudes
  logic [31:0] x1t, den, num, num_mag, den_mag;
  logic [TSideW-1:0] tside_in, tside_out;
  logic        tv;
  logic [31:0] tq;

  assign x1t      = bpc_pkg::sra(prod1, 15);
  assign den      = x1t + cal.md;
  assign num      = {cal.mc[20:0], 11'd0};
  assign num_mag  = num[31] ? 32'd0 - num : num;
  assign den_mag  = den[31] ? 32'd0 - den : den;
  assign tside_in = {x1t, up1, den == 32'd0, num[31] ^ den[31]};

  bpc_div #(.W(32), .SIDE_W(TSideW)) u_tdiv (
    .clk, .rst, .en,
    .in_valid (v1),
    .dividend (num_mag),
    .divisor  (den_mag),
    .side_in  (tside_in),
    .out_valid(tv),
    .quotient (tq),
    .side_out (tside_out)
  );

  logic [31:0] t_x1;
  logic [bpc_pkg::RawPressW-1:0] t_up;
  logic        t_zero, t_neg;
  assign {t_x1, t_up, t_zero, t_neg} = tside_out;

  // stage A: b5, b6
  logic        a_v, a_err;
  logic [31:0] a_b5, a_b6, a_x2;
  logic [bpc_pkg::RawPressW-1:0] a_up;
  assign a_x2 = t_neg ? 32'd0 - tq : tq;

  // stage B..E
  logic        b_v, b_err, c_v, c_err, d_v, d_err, e_v, e_err;
  logic [31:0] b_b5, b_sq, b_ac2, b_ac3;
  logic [31:0] c_b5, c_ac2, c_ac3, c_b2, c_b1;
  logic [31:0] d_b5, d_b3, d_t;
  logic [31:0] e_b5, e_b4, e_b7;
  logic [bpc_pkg::RawPressW-1:0] b_up, c_up, d_up;
  logic [31:0] b6sq, x3a, b3s, x3b, b4p, b7s;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
      e_v <= 1'b0;
    end else if (en) begin
      a_v <= tv;
      b_v <= a_v;
      c_v <= b_v;
      d_v <= c_v;
      e_v <= d_v;
    end
  end

  assign b6sq = bpc_pkg::sra(b_sq, 12);
  assign x3a  = bpc_pkg::sra(c_b2, 11) + bpc_pkg::sra(c_ac2, 11);
  assign b3s  = ((cal.ac1 << 2) + x3a) << cal.oss;
  assign x3b  = bpc_pkg::sra(bpc_pkg::sra(c_ac3, 13) + bpc_pkg::sra(c_b1, 16)
                + bpc_pkg::RoundP, 2);
  assign b4p  = cal.ac4 * d_t;
  assign b7s  = bpc_pkg::B7Scale >> cal.oss;

  always_ff @(posedge clk) begin
    if (en) begin
      a_b5  <= t_x1 + a_x2;
      a_b6  <= t_x1 + a_x2 - bpc_pkg::B6Offset;
      a_up  <= t_up;
      a_err <= t_zero;

      b_sq  <= a_b6 * a_b6;
      b_ac2 <= cal.ac2 * a_b6;
      b_ac3 <= cal.ac3 * a_b6;
      b_b5  <= a_b5;
      b_up  <= a_up;
      b_err <= a_err;

      c_b2  <= cal.b2 * b6sq;
      c_b1  <= cal.b1 * b6sq;
      c_ac2 <= b_ac2;
      c_ac3 <= b_ac3;
      c_b5  <= b_b5;
      c_up  <= b_up;
      c_err <= b_err;

      d_b3  <= bpc_pkg::sra(b3s + bpc_pkg::RoundP, 2);
      d_t   <= x3b + bpc_pkg::B4Bias;
      d_b5  <= c_b5;
      d_up  <= c_up;
      d_err <= c_err;

      e_b4  <= b4p >> 15;
      e_b7  <= ({13'd0, d_up} - d_b3) * b7s;
      e_b5  <= d_b5;
      e_err <= d_err;
    end
  end

  // pressure quotient
  logic [31:0] p_dvd;
  logic [PSideW-1:0] pside_in, pside_out;
  logic        pv;
  logic [31:0] pq;

  assign p_dvd    = e_b7[31] ? e_b7 : {e_b7[30:0], 1'b0};
  assign pside_in = {e_b5, e_err || (e_b4 == 32'd0), e_b7[31]};

  bpc_div #(.W(32), .SIDE_W(PSideW)) u_pdiv (
    .clk, .rst, .en,
    .in_valid (e_v),
    .dividend (p_dvd),
    .divisor  (e_b4),
    .side_in  (pside_in),
    .out_valid(pv),
    .quotient (pq),
    .side_out (pside_out)
  );

  logic [31:0] p_b5;
  logic        p_err, p_big;
  assign {p_b5, p_err, p_big} = pside_out;

  bpc_corr u_corr (
    .clk, .rst, .en,
    .in_valid          (pv),
    .quotient          (pq),
    .b5                (p_b5),
    .err               (p_err),
    .big               (p_big),
    .out_valid         (results.valid),
    .temperature_tenths(results.temperature_tenths),
    .pressure_pa       (results.pressure_pa),
    .divide_error      (results.divide_error)
  );

`ifndef NO_ASSERTIONS
  a_reset_clears: assert property (@(posedge clk) rst |=> !results.valid)
    else $error("result valid after reset");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.divide_error |->
      results.pressure_pa == 0 && results.temperature_tenths == 0)
    else $error("error result not zeroed");
  a_stall_only: assert property (@(posedge clk) disable iff (rst)
    !samples.ready |-> results.valid && !results.ready)
    else $error("input blocked without output stall");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.ready |=> $stable(a_b5) && $stable(e_b7))
    else $error("pipeline moved during stall");
`endif

endmodule
